// File: src/skt_pkg.sv
package skt_pkg;

  localparam int unsigned MAX_KEYS = 32;
  localparam int unsigned IDX_W    = $clog2(MAX_KEYS);
  localparam int unsigned CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned PADDR_W  = 3;

  localparam logic [WIN_W-1:0] MERGE_WINDOW_RESET = 16'd3277;

  // register index, taken from paddr[2]
  localparam logic REG_MERGE_WINDOW = 1'b0;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_NEXT   = 2'd2,
    CMD_PREV   = 2'd3
  } skt_cmd_e;

  typedef struct packed {
    logic        [31:0] key_time;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] look_x;
    logic signed [31:0] look_y;
    logic signed [31:0] look_z;
  } skt_entry_t;

  localparam int unsigned ENTRY_W = $bits(skt_entry_t);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_SET_FULL,
    OP_SCAN_START,
    OP_SCAN_STEP,
    OP_MERGE,
    OP_SHIFT_START,
    OP_SHIFT_STEP,
    OP_PLACE,
    OP_DEL_START,
    OP_DEL_STEP,
    OP_DEL_FINISH,
    OP_STEP_NEXT,
    OP_STEP_PREV,
    OP_READ_SEL,
    OP_LOAD_OUT
  } skt_op_e;

  typedef struct packed {
    skt_cmd_e cmd;
    logic     cnt_zero;
    logic     is_full;
    logic     sel_valid;
    logic     scan_hit;
    logic     scan_last;
    logic     merge_ok;
    logic     shift_last;
    logic     del_tail;
    logic     del_last;
    logic     out_free;
  } skt_status_t;

endpackage

// File: src/skt_ram.sv
module skt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/skt_ctrl.sv
module skt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  skt_pkg::skt_status_t status_i,
  output skt_pkg::skt_op_e    op_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SHIFT,
    ST_PLACE,
    ST_DEL,
    ST_DEL_FIN,
    ST_READ,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = skt_pkg::OP_NOP;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_o    = skt_pkg::OP_LATCH;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (status_i.cmd)
          skt_pkg::CMD_INSERT: begin
            if (status_i.is_full) begin
              op_o    = skt_pkg::OP_SET_FULL;
              state_d = ST_READ;
            end else begin
              op_o    = skt_pkg::OP_SCAN_START;
              state_d = status_i.cnt_zero ? ST_PLACE : ST_SCAN;
            end
          end
          skt_pkg::CMD_DELETE: begin
            if (status_i.cnt_zero || !status_i.sel_valid) begin
              state_d = ST_READ;
            end else begin
              op_o    = skt_pkg::OP_DEL_START;
              state_d = status_i.del_tail ? ST_DEL_FIN : ST_DEL;
            end
          end
          skt_pkg::CMD_NEXT: begin
            op_o    = skt_pkg::OP_STEP_NEXT;
            state_d = ST_READ;
          end
          skt_pkg::CMD_PREV: begin
            op_o    = skt_pkg::OP_STEP_PREV;
            state_d = ST_READ;
          end
          default: state_d = ST_READ;
        endcase
      end
      ST_SCAN: begin
        if (status_i.scan_hit && status_i.merge_ok) begin
          op_o    = skt_pkg::OP_MERGE;
          state_d = ST_READ;
        end else if (status_i.scan_hit || status_i.scan_last) begin
          op_o    = skt_pkg::OP_SHIFT_START;
          state_d = status_i.scan_hit ? ST_SHIFT : ST_PLACE;
        end else begin
          op_o = skt_pkg::OP_SCAN_STEP;
        end
      end
      ST_SHIFT: begin
        op_o = skt_pkg::OP_SHIFT_STEP;
        if (status_i.shift_last) begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        op_o    = skt_pkg::OP_PLACE;
        state_d = ST_READ;
      end
      ST_DEL: begin
        op_o = skt_pkg::OP_DEL_STEP;
        if (status_i.del_last) begin
          state_d = ST_DEL_FIN;
        end
      end
      ST_DEL_FIN: begin
        op_o    = skt_pkg::OP_DEL_FINISH;
        state_d = ST_READ;
      end
      ST_READ: begin
        op_o    = skt_pkg::OP_READ_SEL;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          op_o    = skt_pkg::OP_LOAD_OUT;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// File: src/skt_dp.sv
module skt_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  skt_pkg::skt_op_e                     op_i,
  output skt_pkg::skt_status_t                 status_o,
  input  logic [1:0]                           cmd_i,
  input  skt_pkg::skt_entry_t                  in_entry_i,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [skt_pkg::PADDR_W-1:0]          paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [skt_pkg::CNT_W-1:0]            out_count_o,
  output logic signed [skt_pkg::CNT_W-1:0]     out_sel_o,
  output logic                                 out_full_o,
  output skt_pkg::skt_entry_t                  out_entry_o
);

  localparam int unsigned IW = skt_pkg::IDX_W;
  localparam int unsigned CW = skt_pkg::CNT_W;

  skt_pkg::skt_cmd_e   cmd_q;
  skt_pkg::skt_entry_t new_q;
  logic [skt_pkg::WIN_W-1:0] win_q;
  logic [CW-1:0]        count_q;
  logic signed [CW-1:0] sel_q;
  logic                 full_q;
  logic [IW-1:0]        ptr_q, at_q, wp_q;

  logic                 out_valid_q;
  logic [CW-1:0]        out_count_q;
  logic signed [CW-1:0] out_sel_q;
  logic                 out_full_q;
  skt_pkg::skt_entry_t  out_entry_q;

  logic                 ram_we, ram_re;
  logic [IW-1:0]        ram_waddr, ram_raddr;
  skt_pkg::skt_entry_t  ram_wdata, rd_data;

  logic                 sel_valid;
  logic signed [CW:0]   sel_w, cnt_w, nxt_sum, nxt_sel, prv_sum, prv_sel;
  logic [CW-1:0]        new_count;
  logic                 out_free;

  skt_ram #(
    .WIDTH (skt_pkg::ENTRY_W),
    .DEPTH (skt_pkg::MAX_KEYS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  assign sel_valid = !sel_q[CW-1] && ($unsigned(sel_q) < count_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign sel_w   = {sel_q[CW-1], sel_q};
  assign cnt_w   = $signed({1'b0, count_q});
  assign nxt_sum = sel_w + (CW+1)'(1);
  assign nxt_sel = (nxt_sum >= cnt_w) ? nxt_sum - cnt_w : nxt_sum;
  assign prv_sum = sel_w + cnt_w - (CW+1)'(1);
  always_comb begin
    if (prv_sum < 0) begin
      prv_sel = '0;
    end else if (prv_sum >= cnt_w) begin
      prv_sel = prv_sum - cnt_w;
    end else begin
      prv_sel = prv_sum;
    end
  end
  assign new_count = count_q - CW'(1);

  always_comb begin
    status_o.cmd        = cmd_q;
    status_o.cnt_zero   = (count_q == '0);
    status_o.is_full    = (count_q >= CW'(skt_pkg::MAX_KEYS));
    status_o.sel_valid  = sel_valid;
    status_o.scan_hit   = (rd_data.key_time >= new_q.key_time);
    status_o.scan_last  = (CW'(ptr_q) + CW'(1) == count_q);
    status_o.merge_ok   = ((rd_data.key_time - new_q.key_time) < 32'(win_q));
    status_o.shift_last = ((wp_q - IW'(1)) == at_q);
    status_o.del_tail   = ($unsigned(sel_q) + CW'(1) == count_q);
    status_o.del_last   = (CW'(ptr_q) + CW'(2) == count_q);
    status_o.out_free   = out_free;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = ptr_q;
    ram_raddr = ptr_q;
    ram_wdata = rd_data;
    case (op_i)
      skt_pkg::OP_SCAN_START: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      skt_pkg::OP_SCAN_STEP: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_q + IW'(1);
      end
      skt_pkg::OP_MERGE: begin
        ram_we             = 1'b1;
        ram_wdata          = new_q;
        ram_wdata.key_time = rd_data.key_time;
      end
      skt_pkg::OP_SHIFT_START: begin
        ram_re    = 1'b1;
        ram_raddr = IW'(new_count);
      end
      skt_pkg::OP_SHIFT_STEP: begin
        ram_we    = 1'b1;
        ram_waddr = wp_q;
        ram_re    = 1'b1;
        ram_raddr = wp_q - IW'(2);
      end
      skt_pkg::OP_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = at_q;
        ram_wdata = new_q;
      end
      skt_pkg::OP_DEL_START: begin
        ram_re    = 1'b1;
        ram_raddr = sel_q[IW-1:0] + IW'(1);
      end
      skt_pkg::OP_DEL_STEP: begin
        ram_we    = 1'b1;
        ram_re    = 1'b1;
        ram_raddr = ptr_q + IW'(2);
      end
      skt_pkg::OP_READ_SEL: begin
        ram_re    = 1'b1;
        ram_raddr = sel_q[IW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      skt_pkg::OP_LATCH: begin
        cmd_q <= skt_pkg::skt_cmd_e'(cmd_i);
        new_q <= in_entry_i;
      end
      skt_pkg::OP_SCAN_START: begin
        ptr_q <= '0;
        at_q  <= '0;
      end
      skt_pkg::OP_SCAN_STEP: ptr_q <= ptr_q + IW'(1);
      skt_pkg::OP_SHIFT_START: begin
        at_q <= status_o.scan_hit ? ptr_q : IW'(count_q);
        wp_q <= IW'(count_q);
      end
      skt_pkg::OP_SHIFT_STEP: wp_q <= wp_q - IW'(1);
      skt_pkg::OP_DEL_START: ptr_q <= sel_q[IW-1:0];
      skt_pkg::OP_DEL_STEP: ptr_q <= ptr_q + IW'(1);
      skt_pkg::OP_LOAD_OUT: begin
        out_count_q <= count_q;
        out_sel_q   <= sel_q;
        out_full_q  <= full_q;
        out_entry_q <= sel_valid ? rd_data : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sel_q   <= '1;
      full_q  <= 1'b0;
    end else begin
      case (op_i)
        skt_pkg::OP_SET_FULL: full_q <= 1'b1;
        skt_pkg::OP_MERGE: sel_q <= $signed(CW'(ptr_q));
        skt_pkg::OP_PLACE: begin
          count_q <= count_q + CW'(1);
          sel_q   <= $signed(CW'(at_q));
        end
        skt_pkg::OP_DEL_FINISH: begin
          count_q <= new_count;
          full_q  <= 1'b0;
          if (sel_w >= $signed({1'b0, new_count})) begin
            sel_q <= $signed(new_count - CW'(1));
          end
        end
        skt_pkg::OP_STEP_NEXT: begin
          if (count_q != '0) begin
            sel_q <= CW'(nxt_sel);
          end
        end
        skt_pkg::OP_STEP_PREV: begin
          if (count_q != '0) begin
            sel_q <= CW'(prv_sel);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == skt_pkg::OP_LOAD_OUT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= skt_pkg::MERGE_WINDOW_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == skt_pkg::REG_MERGE_WINDOW)) begin
      win_q <= pwdata[skt_pkg::WIN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == skt_pkg::REG_MERGE_WINDOW) ? 32'(win_q) : '0;

  assign out_valid_o = out_valid_q;
  assign out_count_o = out_count_q;
  assign out_sel_o   = out_sel_q;
  assign out_full_o  = out_full_q;
  assign out_entry_o = out_entry_q;

endmodule

// File: src/sorted_keyframe_table.sv
// Sorted keyframe table: up to 32 keys (time, eye, look) kept in ascending
// time order in one RAM, driven by a small command sequencer.
// Input channel: in_valid_i / in_stall_o with cmd_i and the key fields; an
// item is taken when valid is high and stall is low. Commands are insert,
// delete selected, select next and select previous.
// Output channel: out_valid_o / out_stall_i; every item gives exactly one
// result with the count, selection, full flag and the selected key (zero when
// nothing is selected).
// An insert scans for the first key whose time is not below the new one; if
// that key lies within merge_window, it takes the new eye and look, else the
// later keys shift up and the new key is placed. A delete shifts the later
// keys down. The RAM gives one read and one write per cycle. One item is
// worked on at a time; the next can be taken once the result is in the
// output register, even while stalled. A stalled result holds in the output
// register; a new result waits until it is taken. The APB port writes
// merge_window at address 0; the user must do so only while idle, which the
// block itself does not enforce. Reset empties the table, clears the
// selection to -1 and the full flag, and sets merge_window to 3277 (0.05 s).
// The RAM needs no clearing pass.
module sorted_keyframe_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        cmd_i,
  input  logic [31:0]                       key_time_in_i,
  input  logic signed [31:0]                eye_x_in_i,
  input  logic signed [31:0]                eye_y_in_i,
  input  logic signed [31:0]                eye_z_in_i,
  input  logic signed [31:0]                look_x_in_i,
  input  logic signed [31:0]                look_y_in_i,
  input  logic signed [31:0]                look_z_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [5:0]                        count_out_o,
  output logic signed [5:0]                 selected_out_o,
  output logic                              full_out_o,
  output logic [31:0]                       sel_time_out_o,
  output logic signed [31:0]                sel_eye_x_o,
  output logic signed [31:0]                sel_eye_y_o,
  output logic signed [31:0]                sel_eye_z_o,
  output logic signed [31:0]                sel_look_x_o,
  output logic signed [31:0]                sel_look_y_o,
  output logic signed [31:0]                sel_look_z_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [skt_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  skt_pkg::skt_op_e     op;
  skt_pkg::skt_status_t status;
  skt_pkg::skt_entry_t  in_entry, out_entry;
  logic [skt_pkg::CNT_W-1:0]        out_count;
  logic signed [skt_pkg::CNT_W-1:0] out_sel;

  always_comb begin
    in_entry.key_time = key_time_in_i;
    in_entry.eye_x    = eye_x_in_i;
    in_entry.eye_y    = eye_y_in_i;
    in_entry.eye_z    = eye_z_in_i;
    in_entry.look_x   = look_x_in_i;
    in_entry.look_y   = look_y_in_i;
    in_entry.look_z   = look_z_in_i;
  end

  skt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .op_o       (op)
  );

  skt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .status_o    (status),
    .cmd_i       (cmd_i),
    .in_entry_i  (in_entry),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_count_o (out_count),
    .out_sel_o   (out_sel),
    .out_full_o  (full_out_o),
    .out_entry_o (out_entry)
  );

  assign pready         = 1'b1;
  assign count_out_o    = 6'(out_count);
  assign selected_out_o = 6'(out_sel);
  assign sel_time_out_o = out_entry.key_time;
  assign sel_eye_x_o    = out_entry.eye_x;
  assign sel_eye_y_o    = out_entry.eye_y;
  assign sel_eye_z_o    = out_entry.eye_z;
  assign sel_look_x_o   = out_entry.look_x;
  assign sel_look_y_o   = out_entry.look_y;
  assign sel_look_z_o   = out_entry.look_z;

endmodule
